### rtl/ect_pkg.sv
// Shared types, constants and reset-position helper for the corner tracker.
package ect_pkg;

   // Default corner count and reset geometry
   localparam int N_CORNERS_DEF = 4;
   localparam int MAX_CORNERS   = 16;
   localparam int OBJ_COL_RST   = 120;
   localparam int OBJ_ROW_RST   = 90;
   localparam int RADIUS        = 20;

   // Field and datapath widths
   localparam int POS_W  = 10;
   localparam int CRD_W  = 12;
   localparam int WIN_W  = 9;
   localparam int DIF_W  = 13;
   localparam int RAD_W  = 26;
   localparam int ROOT_W = 13;

   localparam logic [WIN_W-1:0] WIN_RESET = 9'd10;
   localparam logic [CRD_W-1:0] DIST_MAX  = 12'hFFF;

   localparam real PI   = 3.14159265358979323846;
   localparam real SNAP = 1.0 / 65536.0;

   typedef enum logic [1:0] {
      FUNC_EVENT  = 2'd0,
      FUNC_CORNER = 2'd1,
      FUNC_UPDATE = 2'd2,
      FUNC_SPARE  = 2'd3
   } func_type;

   // Operand pair for the distance unit
   typedef enum logic [1:0] {
      SRC_EVT_CORNER = 2'd0,
      SRC_CTR_EVT    = 2'd1,
      SRC_CTR_CORNER = 2'd2
   } src_type;

   typedef struct packed {
      logic    accept;
      logic    win_eval;
      logic    sq_load;
      src_type sq_src;
      logic    sqrt_start;
      logic    inl_eval;
      logic    near_upd;
      logic    div_start;
      logic    div_row;
      logic    cen_wr;
      logic    dist_wr;
      logic    mid_wr;
      logic    out_load;
   } cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic       root_done;
      logic       div_done;
   } sts_type;

   // Reset corner coordinates on a circle, one 12-bit slot per corner.
   // Values that land just below an integer are snapped up to it.
   function automatic logic [MAX_CORNERS*CRD_W-1:0] circle_pos(int ctr, int rad, real step,
                                                               bit use_sin);
      logic [MAX_CORNERS*CRD_W-1:0] pos;
      real v;
      real mag;
      int  ip;
      int  val;
      pos = '0;
      for (int i = 0; i < MAX_CORNERS; i++) begin
         v   = use_sin ? $sin(real'(2 * i + 1) * step) : $cos(real'(2 * i + 1) * step);
         mag = ((v < 0.0) ? -v : v) * real'(rad);
         ip  = int'($floor(mag));
         if (mag - real'(ip) >= 1.0 - SNAP) ip++;
         val = (v < 0.0) ? ctr - ip : ctr + ip;
         pos[i*CRD_W +: CRD_W] = val[CRD_W-1:0];
      end
      return pos;
   endfunction

endpackage

### rtl/ect_isqrt.sv
// Iterative floor square root, one result bit per cycle.
module ect_isqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [ect_pkg::RAD_W-1:0]    radicand,
   output logic                         done,
   output logic [ect_pkg::ROOT_W-1:0]   root
);

   localparam int STEPS = ect_pkg::RAD_W / 2;

   logic [3:0]                  cnt_ff;
   logic                        busy_ff;
   logic                        done_ff;
   logic [ect_pkg::RAD_W-1:0]   v_ff;
   logic [ect_pkg::RAD_W-1:0]   res_ff;

   logic [4:0]                  sh;
   logic [ect_pkg::RAD_W-1:0]   bit_w;
   logic [ect_pkg::RAD_W:0]     trial;
   logic                        ge;

   // Current trial bit walks down two positions per step
   always_comb begin
      sh    = 5'(2 * (STEPS - 1 - int'(cnt_ff)));
      bit_w = ect_pkg::RAD_W'(1) << sh;
      trial = {1'b0, res_ff} + {1'b0, bit_w};
      ge    = ({1'b0, v_ff} >= trial);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 4'd1;
            if (cnt_ff == 4'(STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Remainder and partial root
   always_ff @(posedge clock) begin
      if (start) begin
         v_ff   <= radicand;
         res_ff <= '0;
      end else if (busy_ff) begin
         if (ge) begin
            v_ff   <= v_ff - trial[ect_pkg::RAD_W-1:0];
            res_ff <= (res_ff >> 1) + bit_w;
         end else begin
            res_ff <= res_ff >> 1;
         end
      end
   end

   assign done = done_ff;
   assign root = res_ff[ect_pkg::ROOT_W-1:0];

endmodule

### rtl/ect_div.sv
// Divider by the corner count through a reciprocal multiply, truncating toward zero.
module ect_div #(
   parameter  int N_CORNERS = ect_pkg::N_CORNERS_DEF,
   localparam int DIV_W     = $clog2(N_CORNERS + 1),
   localparam int DV_W      = ect_pkg::CRD_W + 1 + DIV_W
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic signed [DV_W-1:0]           dividend,
   output logic                             done,
   output logic signed [ect_pkg::CRD_W-1:0] quotient
);

   // ceil(2^SH_W / N) is exact for every magnitude below 2^MAG_W since N <= 32
   localparam int MAG_W = DV_W - 1;
   localparam int SH_W  = MAG_W + 5;
   localparam int RCP_W = SH_W + 1;
   localparam int PRD_W = MAG_W + RCP_W;
   localparam logic [RCP_W-1:0] RECIP =
      RCP_W'(((64'd1 << SH_W) + 64'(N_CORNERS) - 64'd1) / 64'(N_CORNERS));

   logic               busy_ff;
   logic               done_ff;
   logic               neg_ff;
   logic [MAG_W-1:0]   mag_ff;
   logic [MAG_W-1:0]   quo_ff;

   logic [DV_W-1:0]    abs_val;
   logic [PRD_W-1:0]   prod;
   logic [MAG_W-1:0]   q_signed;

   always_comb begin
      abs_val  = dividend[DV_W-1] ? DV_W'(-dividend) : DV_W'(dividend);
      prod     = {{RCP_W{1'b0}}, mag_ff} * {{MAG_W{1'b0}}, RECIP};
      q_signed = neg_ff ? (~quo_ff + MAG_W'(1)) : quo_ff;
   end

   // Magnitude registered on start, product registered in the cycle after
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= start;
         done_ff <= busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff <= dividend[DV_W-1];
         mag_ff <= abs_val[MAG_W-1:0];
      end
      if (busy_ff) quo_ff <= prod[SH_W +: MAG_W];
   end

   assign done     = done_ff;
   assign quotient = q_signed[ect_pkg::CRD_W-1:0];

endmodule

### rtl/ect_dpath.sv
// Tracker datapath: corner store, center, distance and divide units, result register.
module ect_dpath #(
   parameter  int N_CORNERS = ect_pkg::N_CORNERS_DEF,
   localparam int CW        = (N_CORNERS > 1) ? $clog2(N_CORNERS) : 1
) (
   input  logic                             clock,
   input  logic                             reset,
   input  ect_pkg::cmd_type                 cmd,
   input  logic [CW-1:0]                    idx,
   output ect_pkg::sts_type                 sts,
   input  logic [1:0]                       req_func,
   input  logic [ect_pkg::POS_W-1:0]        req_pos_x,
   input  logic [ect_pkg::POS_W-1:0]        req_pos_y,
   input  logic                             csr_wr_en,
   input  logic [ect_pkg::WIN_W-1:0]        csr_wr_data,
   output logic                             rsp_hit,
   output logic signed [ect_pkg::CRD_W-1:0] rsp_center_col,
   output logic signed [ect_pkg::CRD_W-1:0] rsp_center_row
);

   localparam int  CRD_W  = ect_pkg::CRD_W;
   localparam int  DIF_W  = ect_pkg::DIF_W;
   localparam int  ROOT_W = ect_pkg::ROOT_W;
   localparam int  SQ_W   = ect_pkg::RAD_W - 1;
   localparam int  DIV_W  = $clog2(N_CORNERS + 1);
   localparam int  DV_W   = CRD_W + 1 + DIV_W;
   localparam real ANG_STEP = ect_pkg::PI / N_CORNERS;
   localparam logic [ect_pkg::MAX_CORNERS*CRD_W-1:0] INIT_COL =
      ect_pkg::circle_pos(ect_pkg::OBJ_COL_RST, ect_pkg::RADIUS, ANG_STEP, 1'b0);
   localparam logic [ect_pkg::MAX_CORNERS*CRD_W-1:0] INIT_ROW =
      ect_pkg::circle_pos(ect_pkg::OBJ_ROW_RST, ect_pkg::RADIUS, ANG_STEP, 1'b1);

   // Architectural state
   logic signed [CRD_W-1:0]     col_ff [N_CORNERS];
   logic signed [CRD_W-1:0]     row_ff [N_CORNERS];
   logic [CRD_W-1:0]            dist_ff [N_CORNERS];
   logic signed [CRD_W-1:0]     ccol_ff;
   logic signed [CRD_W-1:0]     crow_ff;
   logic [ect_pkg::WIN_W-1:0]   win_ff;

   // Per-request working registers
   logic [1:0]                  func_ff;
   logic [ect_pkg::POS_W-1:0]   x_ff;
   logic [ect_pkg::POS_W-1:0]   y_ff;
   logic [N_CORNERS-1:0]        flags_ff;
   logic [ROOT_W-1:0]           dmin_ff;
   logic [CW-1:0]               m_ff;
   logic signed [CRD_W-1:0]     mcol_ff;
   logic signed [CRD_W-1:0]     mrow_ff;
   logic [SQ_W-1:0]             sqx_ff;
   logic [SQ_W-1:0]             sqy_ff;
   logic                        hit_ff;
   logic signed [CRD_W-1:0]     ocol_ff;
   logic signed [CRD_W-1:0]     orow_ff;

   logic signed [DIF_W-1:0]     xs;
   logic signed [DIF_W-1:0]     ys;
   logic signed [DIF_W-1:0]     dx;
   logic signed [DIF_W-1:0]     dy;
   logic signed [2*DIF_W-1:0]   sqx;
   logic signed [2*DIF_W-1:0]   sqy;
   logic [ect_pkg::RAD_W-1:0]   radicand;
   logic                        root_done;
   logic [ROOT_W-1:0]           root;
   logic [N_CORNERS-1:0]        win_flags;
   logic [N_CORNERS-1:0]        inl_fail;
   logic signed [DV_W-1:0]      dividend;
   logic                        div_done;
   logic signed [CRD_W-1:0]     quotient;
   logic [CRD_W-1:0]            dist_sat;
   logic signed [CRD_W-1:0]     mid_col;
   logic signed [CRD_W-1:0]     mid_row;
   logic                        hit_val;

   // Truncating midpoint of a pixel coordinate and a corner coordinate
   function automatic logic signed [CRD_W-1:0] midpoint(logic [ect_pkg::POS_W-1:0] p,
                                                       logic signed [CRD_W-1:0] c);
      logic signed [DIF_W-1:0] s;
      logic signed [DIF_W-1:0] h;
      s = $signed(DIF_W'(p)) + DIF_W'(c);
      h = (s + $signed(DIF_W'(s[DIF_W-1]))) >>> 1;
      return h[CRD_W-1:0];
   endfunction

   assign xs = $signed(DIF_W'(x_ff));
   assign ys = $signed(DIF_W'(y_ff));

   // Difference pair feeding the squarers
   always_comb begin
      case (cmd.sq_src)
         ect_pkg::SRC_EVT_CORNER: begin
            dx = xs - DIF_W'(col_ff[idx]);
            dy = ys - DIF_W'(row_ff[idx]);
         end
         ect_pkg::SRC_CTR_EVT: begin
            dx = DIF_W'(ccol_ff) - xs;
            dy = DIF_W'(crow_ff) - ys;
         end
         default: begin
            dx = DIF_W'(ccol_ff) - DIF_W'(col_ff[idx]);
            dy = DIF_W'(crow_ff) - DIF_W'(row_ff[idx]);
         end
      endcase
      sqx      = dx * dx;
      sqy      = dy * dy;
      radicand = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   end

   // Window and inlier tests across all corners
   always_comb begin
      logic signed [DIF_W:0] we;
      we = $signed((DIF_W+1)'(win_ff));
      for (int i = 0; i < N_CORNERS; i++) begin
         win_flags[i] = ($signed((DIF_W+1)'(x_ff)) > (DIF_W+1)'(col_ff[i]) - we) &&
                        ($signed((DIF_W+1)'(x_ff)) < (DIF_W+1)'(col_ff[i]) + we) &&
                        ($signed((DIF_W+1)'(y_ff)) > (DIF_W+1)'(row_ff[i]) - we) &&
                        ($signed((DIF_W+1)'(y_ff)) < (DIF_W+1)'(row_ff[i]) + we);
         inl_fail[i]  = root > {dist_ff[i], 1'b0};
      end
   end

   // Center move dividend: c*N - matched corner + event
   always_comb begin
      if (cmd.div_row) begin
         dividend = DV_W'(crow_ff) * $signed(DV_W'(N_CORNERS)) - DV_W'(mrow_ff)
                    + $signed(DV_W'(y_ff));
      end else begin
         dividend = DV_W'(ccol_ff) * $signed(DV_W'(N_CORNERS)) - DV_W'(mcol_ff)
                    + $signed(DV_W'(x_ff));
      end
   end

   always_comb begin
      dist_sat = (root > ROOT_W'(ect_pkg::DIST_MAX)) ? ect_pkg::DIST_MAX : root[CRD_W-1:0];
      mid_col  = midpoint(x_ff, mcol_ff);
      mid_row  = midpoint(y_ff, mrow_ff);
      case (func_ff)
         ect_pkg::FUNC_EVENT:  hit_val = |flags_ff;
         ect_pkg::FUNC_CORNER: hit_val = ~|flags_ff;
         default:              hit_val = 1'b0;
      endcase
   end

   ect_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.sqrt_start),
      .radicand (radicand),
      .done     (root_done),
      .root     (root)
   );

   ect_div #(.N_CORNERS(N_CORNERS)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .done     (div_done),
      .quotient (quotient)
   );

   // Tracker state: corners, distances, center, window
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N_CORNERS; i++) begin
            col_ff[i]  <= INIT_COL[i*CRD_W +: CRD_W];
            row_ff[i]  <= INIT_ROW[i*CRD_W +: CRD_W];
            dist_ff[i] <= CRD_W'(ect_pkg::RADIUS);
         end
         ccol_ff <= CRD_W'(ect_pkg::OBJ_COL_RST);
         crow_ff <= CRD_W'(ect_pkg::OBJ_ROW_RST);
         win_ff  <= ect_pkg::WIN_RESET;
      end else begin
         if (csr_wr_en) win_ff <= csr_wr_data;
         if (cmd.cen_wr) begin
            if (cmd.div_row) crow_ff <= quotient;
            else             ccol_ff <= quotient;
         end
         if (cmd.dist_wr) dist_ff[idx] <= dist_sat;
         if (cmd.mid_wr) begin
            col_ff[m_ff] <= mid_col;
            row_ff[m_ff] <= mid_row;
         end
      end
   end

   // Request working registers and result register
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         func_ff  <= req_func;
         x_ff     <= req_pos_x;
         y_ff     <= req_pos_y;
         flags_ff <= '0;
         dmin_ff  <= ROOT_W'({win_ff, 1'b0});
         m_ff     <= '0;
         mcol_ff  <= col_ff[0];
         mrow_ff  <= row_ff[0];
      end
      if (cmd.win_eval) flags_ff <= win_flags;
      if (cmd.inl_eval) flags_ff <= inl_fail;
      if (cmd.sq_load) begin
         sqx_ff <= sqx[SQ_W-1:0];
         sqy_ff <= sqy[SQ_W-1:0];
      end
      // strict less-than keeps the earliest nearest corner
      if (cmd.near_upd && (root < dmin_ff)) begin
         dmin_ff <= root;
         m_ff    <= idx;
         mcol_ff <= col_ff[idx];
         mrow_ff <= row_ff[idx];
      end
      if (cmd.out_load) begin
         hit_ff  <= hit_val;
         ocol_ff <= ccol_ff;
         orow_ff <= crow_ff;
      end
   end

   assign sts.func      = func_ff;
   assign sts.root_done = root_done;
   assign sts.div_done  = div_done;

   assign rsp_hit        = hit_ff;
   assign rsp_center_col = ocol_ff;
   assign rsp_center_row = orow_ff;

endmodule

### rtl/ect_ctrl.sv
// Tracker sequencer: walks each request through the datapath and owns the handshakes.
module ect_ctrl #(
   parameter  int N_CORNERS = ect_pkg::N_CORNERS_DEF,
   localparam int CW        = (N_CORNERS > 1) ? $clog2(N_CORNERS) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [1:0]          req_func,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output ect_pkg::cmd_type    cmd,
   output logic [CW-1:0]       idx,
   input  ect_pkg::sts_type    sts
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_WIN, ST_SQ, ST_ROOT, ST_WAIT, ST_INL, ST_NEAR,
      ST_DIVC, ST_DIVC_W, ST_DIVR, ST_DIVR_W, ST_DIST, ST_MID, ST_FIN
   } state_type;

   typedef enum logic [1:0] {PH_INL, PH_NEAR, PH_DIST} phase_type;

   state_type  state_ff;
   state_type  state_in;
   phase_type  phase_ff;
   phase_type  phase_in;
   logic [CW-1:0] idx_ff;
   logic [CW-1:0] idx_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       accept;
   logic       last;
   logic       out_free;

   assign accept   = (state_ff == ST_IDLE) && req_valid;
   assign last     = (idx_ff == CW'(N_CORNERS - 1));
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      unique case (phase_ff)
         PH_INL:  cmd.sq_src = ect_pkg::SRC_CTR_EVT;
         PH_NEAR: cmd.sq_src = ect_pkg::SRC_EVT_CORNER;
         default: cmd.sq_src = ect_pkg::SRC_CTR_CORNER;
      endcase
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.accept = 1'b1;
               idx_in     = '0;
               case (req_func)
                  ect_pkg::FUNC_EVENT: state_in = ST_WIN;
                  ect_pkg::FUNC_CORNER: begin
                     phase_in = PH_INL;
                     state_in = ST_SQ;
                  end
                  ect_pkg::FUNC_UPDATE: begin
                     phase_in = PH_NEAR;
                     state_in = ST_SQ;
                  end
                  default: state_in = ST_FIN;
               endcase
            end
         end
         ST_WIN: begin
            cmd.win_eval = 1'b1;
            state_in     = ST_FIN;
         end
         ST_SQ: begin
            cmd.sq_load = 1'b1;
            state_in    = ST_ROOT;
         end
         ST_ROOT: begin
            cmd.sqrt_start = 1'b1;
            state_in       = ST_WAIT;
         end
         ST_WAIT: begin
            if (sts.root_done) begin
               unique case (phase_ff)
                  PH_INL:  state_in = ST_INL;
                  PH_NEAR: state_in = ST_NEAR;
                  default: state_in = ST_DIST;
               endcase
            end
         end
         ST_INL: begin
            cmd.inl_eval = 1'b1;
            state_in     = ST_FIN;
         end
         ST_NEAR: begin
            cmd.near_upd = 1'b1;
            if (last) state_in = ST_DIVC;
            else begin
               idx_in   = idx_ff + CW'(1);
               state_in = ST_SQ;
            end
         end
         ST_DIVC: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIVC_W;
         end
         ST_DIVC_W: begin
            if (sts.div_done) begin
               cmd.cen_wr = 1'b1;
               state_in   = ST_DIVR;
            end
         end
         ST_DIVR: begin
            cmd.div_row   = 1'b1;
            cmd.div_start = 1'b1;
            state_in      = ST_DIVR_W;
         end
         ST_DIVR_W: begin
            cmd.div_row = 1'b1;
            if (sts.div_done) begin
               cmd.cen_wr = 1'b1;
               idx_in     = '0;
               phase_in   = PH_DIST;
               state_in   = ST_SQ;
            end
         end
         ST_DIST: begin
            cmd.dist_wr = 1'b1;
            if (last) state_in = ST_MID;
            else begin
               idx_in   = idx_ff + CW'(1);
               state_in = ST_SQ;
            end
         end
         ST_MID: begin
            cmd.mid_wr = 1'b1;
            state_in   = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_INL;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign idx       = idx_ff;

   // Checks
   a_root_in_wait: assert property (@(posedge clock) disable iff (reset)
      sts.root_done |-> (state_ff == ST_WAIT))
      else $error("root result outside wait state");

   a_div_in_wait: assert property (@(posedge clock) disable iff (reset)
      sts.div_done |-> (state_ff == ST_DIVC_W || state_ff == ST_DIVR_W))
      else $error("divide result outside wait state");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("request taken while busy");

   a_load_gives_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid)
      else $error("loaded result not presented");

endmodule

### rtl/event_corner_object_tracker.sv
// Event-camera corner object tracker, one request in flight at a time.
// An event window test compares against every corner at once; a corner inlier test makes one
// pass of the 13-step square-root unit; an update makes two walks over the corners
// with one square root per corner, plus two reciprocal divides (column, then row).
// Next request is taken the cycle after the response loads; a stalled response holds it off.
// Synchronous reset restores circle corners, distances, center and window; no clearing pass.
module event_corner_object_tracker #(
   parameter int N_CORNERS = ect_pkg::N_CORNERS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_func,
   input  logic [ect_pkg::POS_W-1:0]        req_pos_x,
   input  logic [ect_pkg::POS_W-1:0]        req_pos_y,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_hit,
   output logic signed [ect_pkg::CRD_W-1:0] rsp_center_col,
   output logic signed [ect_pkg::CRD_W-1:0] rsp_center_row,
   input  logic                             csr_wr_en,
   input  logic [ect_pkg::WIN_W-1:0]        csr_wr_data
);

   localparam int CW = (N_CORNERS > 1) ? $clog2(N_CORNERS) : 1;

   ect_pkg::cmd_type cmd;
   ect_pkg::sts_type sts;
   logic [CW-1:0]    idx;

   ect_ctrl #(.N_CORNERS(N_CORNERS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .idx       (idx),
      .sts       (sts)
   );

   ect_dpath #(.N_CORNERS(N_CORNERS)) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .idx            (idx),
      .sts            (sts),
      .req_func       (req_func),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .rsp_hit        (rsp_hit),
      .rsp_center_col (rsp_center_col),
      .rsp_center_row (rsp_center_row)
   );

endmodule

### dv/ect_tracker_checker.sv
// Checker for the corner tracker: watches both channels, predicts each response, compares.
module ect_tracker_checker #(
   parameter int N_CORNERS = ect_pkg::N_CORNERS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  logic [1:0]                       req_func,
   input  logic [ect_pkg::POS_W-1:0]        req_pos_x,
   input  logic [ect_pkg::POS_W-1:0]        req_pos_y,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  logic                             rsp_hit,
   input  logic signed [ect_pkg::CRD_W-1:0] rsp_center_col,
   input  logic signed [ect_pkg::CRD_W-1:0] rsp_center_row,
   input  logic                             csr_wr_en,
   input  logic [ect_pkg::WIN_W-1:0]        csr_wr_data,
   output int                               errors,
   output int                               pending,
   output int                               hit_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CRD_W = ect_pkg::CRD_W;

   typedef struct {
      logic                    hit;
      logic signed [CRD_W-1:0] col;
      logic signed [CRD_W-1:0] row;
   } track_type;

   track_type expected_tracks[$];

   // Tracker state mirror
   longint trk_col[N_CORNERS];
   longint trk_row[N_CORNERS];
   longint trk_dist[N_CORNERS];
   longint ctr_col;
   longint ctr_row;
   longint window;

   function automatic longint to_s12(longint v);
      logic signed [CRD_W-1:0] t;
      t = v[CRD_W-1:0];
      return longint'(t);
   endfunction

   function automatic longint floor_root(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      for (int k = 31; k >= 0; k--) begin
         b = r | (64'd1 << k);
         if (b * b <= v) r = b;
      end
      return longint'(r);
   endfunction

   function automatic longint span(longint dx, longint dy);
      return floor_root(longint'(dx * dx + dy * dy));
   endfunction

   // Circle offset: trunc(RADIUS * v), values just below an integer snap up
   function automatic longint circle_offset(real v);
      real    mag;
      longint ip;
      mag = ((v < 0.0) ? -v : v) * real'(ect_pkg::RADIUS);
      ip  = longint'($floor(mag));
      if (mag - real'(ip) >= 1.0 - 1.0 / 65536.0) ip++;
      return (v < 0.0) ? -ip : ip;
   endfunction

   task automatic restore_tracker();
      real ang;
      for (int i = 0; i < N_CORNERS; i++) begin
         ang        = real'(2 * i + 1) * 3.14159265358979323846 / real'(N_CORNERS);
         trk_col[i] = to_s12(ect_pkg::OBJ_COL_RST + circle_offset($cos(ang)));
         trk_row[i] = to_s12(ect_pkg::OBJ_ROW_RST + circle_offset($sin(ang)));
         trk_dist[i] = ect_pkg::RADIUS;
      end
      ctr_col = ect_pkg::OBJ_COL_RST;
      ctr_row = ect_pkg::OBJ_ROW_RST;
      window  = longint'(ect_pkg::WIN_RESET);
   endtask

   // Apply one request to the mirror and return the response it causes
   function automatic track_type track_request(logic [1:0] fn, longint x, longint y);
      track_type res;
      longint    dmin;
      longint    d;
      longint    off;
      int        m;
      res.hit = 1'b0;
      case (fn)
         ect_pkg::FUNC_EVENT: begin
            for (int i = 0; i < N_CORNERS; i++)
               if (x > trk_col[i] - window && x < trk_col[i] + window &&
                   y > trk_row[i] - window && y < trk_row[i] + window)
                  res.hit = 1'b1;
         end
         ect_pkg::FUNC_CORNER: begin
            off     = span(ctr_col - x, ctr_row - y);
            res.hit = 1'b1;
            for (int i = 0; i < N_CORNERS; i++)
               if (off > 2 * trk_dist[i]) res.hit = 1'b0;
         end
         ect_pkg::FUNC_UPDATE: begin
            dmin = 2 * window;
            m    = 0;
            for (int i = 0; i < N_CORNERS; i++) begin
               d = span(x - trk_col[i], y - trk_row[i]);
               if (d < dmin) begin
                  m    = i;
                  dmin = d;
               end
            end
            ctr_col = to_s12((ctr_col * N_CORNERS - trk_col[m] + x) / N_CORNERS);
            ctr_row = to_s12((ctr_row * N_CORNERS - trk_row[m] + y) / N_CORNERS);
            for (int i = 0; i < N_CORNERS; i++) begin
               d           = span(ctr_col - trk_col[i], ctr_row - trk_row[i]);
               trk_dist[i] = (d > 4095) ? 4095 : d;
            end
            trk_col[m] = to_s12((x + trk_col[m]) / 2);
            trk_row[m] = to_s12((y + trk_row[m]) / 2);
         end
         default: ;
      endcase
      res.col = ctr_col[CRD_W-1:0];
      res.row = ctr_row[CRD_W-1:0];
      return res;
   endfunction

   initial begin
      errors    = 0;
      hit_count = 0;
      restore_tracker();
   end

   assign pending = expected_tracks.size();

   always @(posedge clock) begin
      track_type want;
      if (reset) begin
         restore_tracker();
         expected_tracks.delete();
      end else begin
         if (csr_wr_en) window = longint'(csr_wr_data);
         // Predict on each accepted request
         if (req_valid && !req_stall)
            expected_tracks.push_back(track_request(req_func, longint'(req_pos_x),
                                                    longint'(req_pos_y)));
         // Compare each accepted response with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (rsp_hit) hit_count++;
            if (expected_tracks.size() == 0) begin
               errors++;
               if (errors <= 10) $display("%t unexpected response", $realtime);
            end else begin
               want = expected_tracks.pop_front();
               if (rsp_hit !== want.hit || rsp_center_col !== want.col ||
                   rsp_center_row !== want.row) begin
                  errors++;
                  if (errors <= 10)
                     $display("%t mismatch: exp hit=%0d ctr=(%0d,%0d) got hit=%0d ctr=(%0d,%0d)",
                              $realtime, want.hit, want.col, want.row,
                              rsp_hit, rsp_center_col, rsp_center_row);
               end
            end
         end
      end
   end

endmodule

### dv/tb_event_corner_object_tracker.sv
// Testbench top for the corner tracker: clock, reset, stimulus, pressure and verdict.
module tb_event_corner_object_tracker;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 5000;
   localparam int DRAIN_WAIT  = 250;
   localparam int POS_W       = ect_pkg::POS_W;
   localparam int CRD_W       = ect_pkg::CRD_W;
   localparam int WIN_W       = ect_pkg::WIN_W;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic [1:0]              req_func;
   logic [POS_W-1:0]        req_pos_x;
   logic [POS_W-1:0]        req_pos_y;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic                    rsp_hit;
   logic signed [CRD_W-1:0] rsp_center_col;
   logic signed [CRD_W-1:0] rsp_center_row;
   logic                    csr_wr_en;
   logic [WIN_W-1:0]        csr_wr_data;

   int errors;
   int pending;
   int hit_count;
   int send_idle;
   int recv_idle;
   int hold_cycles;
   int quiet_cycles;
   int requests_sent;

   event_corner_object_tracker uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_func(req_func),
      .req_pos_x(req_pos_x), .req_pos_y(req_pos_y),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_hit(rsp_hit),
      .rsp_center_col(rsp_center_col), .rsp_center_row(rsp_center_row),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   ect_tracker_checker chk (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_func(req_func),
      .req_pos_x(req_pos_x), .req_pos_y(req_pos_y),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_hit(rsp_hit),
      .rsp_center_col(rsp_center_col), .rsp_center_row(rsp_center_row),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .errors(errors), .pending(pending), .hit_count(hit_count)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Response side: random stall, or a long hold-off when requested
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall   <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle);
      end
   end

   // Watchdog on cycles without any accepted request or response
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one request and hold it until accepted; valid stays high afterwards
   task automatic send_request(logic [1:0] fn, int x, int y);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func  <= fn;
      req_pos_x <= x[POS_W-1:0];
      req_pos_y <= y[POS_W-1:0];
      do @(posedge clock); while (req_stall);
      requests_sent++;
   endtask

   // Drain outstanding responses, then let the block settle and write the window
   task automatic set_window(int w);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= w[WIN_W-1:0];
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic random_requests(int count);
      int fn;
      int pick;
      int x;
      int y;
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(99);
         fn   = (pick < 40) ? ect_pkg::FUNC_EVENT : (pick < 65) ? ect_pkg::FUNC_CORNER :
                (pick < 95) ? ect_pkg::FUNC_UPDATE : ect_pkg::FUNC_SPARE;
         // mostly near the reset object, some anywhere on the sensor
         if ($urandom_range(99) < 80) begin
            x = $urandom_range(180, 60);
            y = $urandom_range(150, 30);
         end else begin
            x = $urandom_range(1023);
            y = $urandom_range(1023);
         end
         send_request(fn[1:0], x, y);
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_func      = ect_pkg::FUNC_EVENT;
      req_pos_x     = '0;
      req_pos_y     = '0;
      rsp_stall     = 1'b0;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      send_idle     = 9;
      recv_idle     = 51;
      hold_cycles   = 0;
      quiet_cycles  = 0;
      requests_sent = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: window edges, inlier test, ties, far updates, unused selector
      send_request(ect_pkg::FUNC_EVENT, 125, 104);
      send_request(ect_pkg::FUNC_EVENT, 124, 104);
      send_request(ect_pkg::FUNC_EVENT, 106, 85);
      send_request(ect_pkg::FUNC_EVENT, 0, 0);
      send_request(ect_pkg::FUNC_EVENT, 1023, 1023);
      send_request(ect_pkg::FUNC_CORNER, 120, 90);
      send_request(ect_pkg::FUNC_CORNER, 160, 90);
      send_request(ect_pkg::FUNC_CORNER, 161, 90);
      send_request(ect_pkg::FUNC_CORNER, 1023, 0);
      send_request(ect_pkg::FUNC_UPDATE, 120, 104);
      send_request(ect_pkg::FUNC_UPDATE, 134, 76);
      send_request(ect_pkg::FUNC_SPARE, 1023, 1023);
      send_request(ect_pkg::FUNC_UPDATE, 1023, 1023);
      send_request(ect_pkg::FUNC_UPDATE, 0, 0);
      send_request(ect_pkg::FUNC_EVENT, 682, 341);
      send_request(ect_pkg::FUNC_CORNER, 341, 682);

      // Zero window: no event hits, updates always take corner 0
      set_window(0);
      send_request(ect_pkg::FUNC_EVENT, 134, 104);
      send_request(ect_pkg::FUNC_UPDATE, 106, 76);
      send_request(ect_pkg::FUNC_EVENT, 120, 90);

      // Widest window, with a long response hold-off so the block backs up
      set_window(511);
      hold_cycles = 600;
      random_requests(110);

      set_window(1);
      send_idle = 51;
      recv_idle = 9;
      random_requests(110);

      set_window($urandom_range(40, 2));
      send_idle = 0;
      recv_idle = 0;
      random_requests(110);

      set_window(10);
      random_requests(90);

      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("Covered %0d requests over window settings 0, 1, 10, 511 and one random;",
               requests_sent);
      $display("%0d responses flagged a hit, with idle, stall and hold-off mixes.", hit_count);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/ect_pkg.sv
rtl/ect_isqrt.sv
rtl/ect_div.sv
rtl/ect_dpath.sv
rtl/ect_ctrl.sv
rtl/event_corner_object_tracker.sv
dv/ect_tracker_checker.sv
dv/tb_event_corner_object_tracker.sv
